/* rtl/outline_bezier_flattener_assert.svh */
// assertion helpers for the outline flattener, clocked on clk and quiet in reset
`ifndef OUTLINE_BEZIER_FLATTENER_ASSERT_SVH
`define OUTLINE_BEZIER_FLATTENER_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define OBF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define OBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/obf_pkg.sv */
package obf_pkg;

  localparam int COORD_BITS   = 24;
  localparam int STEP_BITS    = 16;
  localparam int K_BITS       = 6;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [K_BITS-1:0]       MAX_INTERP     = 6'd63;
  localparam logic [STEP_BITS-1:0]    STEP_RESET     = 16'd6554;
  localparam logic                    CURVE_RESET    = 1'b1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CURVE_MODE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PARAM_STEP = 2'd1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    CMD_MOVE,
    CMD_LINE,
    CMD_CONIC,
    CMD_CUBIC
  } cmd_t;

  typedef struct packed {
    cmd_t   command;
    coord_t ctrl1_x;
    coord_t ctrl1_y;
    coord_t ctrl2_x;
    coord_t ctrl2_y;
    coord_t end_x;
    coord_t end_y;
  } obf_in_t;

  typedef struct packed {
    coord_t vert_x;
    coord_t vert_y;
    logic   new_contour;
    logic   last_vertex;
  } obf_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAIN_C2,
    ST_PLAIN_END,
    ST_CALC_ISSUE,
    ST_CALC_WAIT,
    ST_CURVE_END,
    ST_EMIT
  } state_t;

  // operand sources and destinations of one interpolation step
  typedef enum logic [2:0] {
    SRC_PEN,
    SRC_C1,
    SRC_C2,
    SRC_END,
    SRC_S0,
    SRC_S1,
    SRC_S2
  } src_t;

  typedef enum logic [1:0] {
    DST_S0,
    DST_S1,
    DST_S2,
    DST_RES
  } dst_t;

  typedef struct packed {
    src_t src_a;
    src_t src_b;
    dst_t dst;
    logic last;
  } uop_t;

  // de casteljau schedule for one axis: three steps for a conic, six for a cubic
  function automatic uop_t uop_lookup(input logic cubic, input logic [2:0] idx);
    uop_t u;
    u = '{src_a: SRC_PEN, src_b: SRC_PEN, dst: DST_RES, last: 1'b1};
    unique case ({cubic, idx})
      4'b0_000: u = '{src_a: SRC_PEN, src_b: SRC_C1,  dst: DST_S0,  last: 1'b0};
      4'b0_001: u = '{src_a: SRC_C1,  src_b: SRC_END, dst: DST_S1,  last: 1'b0};
      4'b0_010: u = '{src_a: SRC_S0,  src_b: SRC_S1,  dst: DST_RES, last: 1'b1};
      4'b1_000: u = '{src_a: SRC_PEN, src_b: SRC_C1,  dst: DST_S0,  last: 1'b0};
      4'b1_001: u = '{src_a: SRC_C1,  src_b: SRC_C2,  dst: DST_S1,  last: 1'b0};
      4'b1_010: u = '{src_a: SRC_C2,  src_b: SRC_END, dst: DST_S2,  last: 1'b0};
      4'b1_011: u = '{src_a: SRC_S0,  src_b: SRC_S1,  dst: DST_S0,  last: 1'b0};
      4'b1_100: u = '{src_a: SRC_S1,  src_b: SRC_S2,  dst: DST_S1,  last: 1'b0};
      4'b1_101: u = '{src_a: SRC_S0,  src_b: SRC_S1,  dst: DST_RES, last: 1'b1};
      default:  u = '{src_a: SRC_PEN, src_b: SRC_PEN, dst: DST_RES, last: 1'b1};
    endcase
    return u;
  endfunction

endpackage

/* rtl/obf_lerp.sv */
module obf_lerp import obf_pkg::*; #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  coord_t                 a,
  input  coord_t                 b,
  input  logic [T_FRAC_BITS-1:0] t,
  output logic                   done,
  output coord_t                 res
);

  localparam int PW = COORD_BITS + T_FRAC_BITS + 2;

  logic signed [COORD_BITS:0]  diff;
  logic signed [T_FRAC_BITS:0] t_s;
  logic signed [PW-1:0]        prod;
  logic signed [PW-1:0]        prod_r;
  logic signed [PW-1:0]        shifted;
  logic signed [COORD_BITS:0]  q;
  logic signed [COORD_BITS:0]  sum;
  coord_t                      a_r;
  coord_t                      res_r;
  logic                        v1_r;
  logic                        v2_r;

  assign diff    = (COORD_BITS+1)'(b) - (COORD_BITS+1)'(a);
  assign t_s     = $signed({1'b0, t});
  assign prod    = PW'(diff) * PW'(t_s);
  // arithmetic shift gives the floor of the scaled difference
  assign shifted = prod_r >>> T_FRAC_BITS;
  assign q       = shifted[COORD_BITS:0];
  assign sum     = (COORD_BITS+1)'(a_r) + q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= a;
      prod_r <= prod;
    end
    if (v1_r) begin
      res_r <= sum[COORD_BITS-1:0];
    end
  end

  assign done = v2_r;
  assign res  = res_r;

endmodule

/* rtl/obf_core.sv */
module obf_core import obf_pkg::*; #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 curve_mode,
  input  logic [STEP_BITS-1:0] param_step,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  obf_in_t              in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output obf_out_t             out_word
);

  localparam int TW = ((T_FRAC_BITS > STEP_BITS) ? T_FRAC_BITS : STEP_BITS) + 1;
  localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;

  state_t          state_r, state_nxt;
  state_t          resume_r, resume_nxt;
  obf_in_t         item_r, item_nxt;
  logic            at_start_r, at_start_nxt;
  coord_t          pen_x_r, pen_x_nxt, pen_y_r, pen_y_nxt;
  coord_t          start_x_r, start_x_nxt, start_y_r, start_y_nxt;
  logic            nonempty_r, nonempty_nxt;
  logic [TW-1:0]   t_r, t_nxt;
  logic [K_BITS-1:0] k_r, k_nxt;
  logic [2:0]      uidx_r, uidx_nxt;
  logic            axis_r, axis_nxt;
  coord_t          s0_r, s0_nxt, s1_r, s1_nxt, s2_r, s2_nxt;
  coord_t          vx_r, vx_nxt, vy_r, vy_nxt;
  logic            nc_r, nc_nxt, last_r, last_nxt;
  logic            out_valid_r, out_valid_nxt;
  obf_out_t        out_word_r, out_word_nxt;

  uop_t            uop;
  coord_t          opa, opb, lerp_res;
  logic            lerp_start, lerp_done;
  logic [TW-1:0]   t_sum, step_ext;
  logic [K_BITS-1:0] k_inc;
  logic            more;
  logic            out_free;
  logic            in_at_start;

  function automatic coord_t pick(input src_t s);
    coord_t v;
    case (s)
      SRC_PEN: v = axis_r ? pen_y_r : pen_x_r;
      SRC_C1:  v = axis_r ? item_r.ctrl1_y : item_r.ctrl1_x;
      SRC_C2:  v = axis_r ? item_r.ctrl2_y : item_r.ctrl2_x;
      SRC_END: v = axis_r ? item_r.end_y : item_r.end_x;
      SRC_S0:  v = s0_r;
      SRC_S1:  v = s1_r;
      SRC_S2:  v = s2_r;
      default: v = '0;
    endcase
    return v;
  endfunction

  obf_lerp #(
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_lerp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lerp_start),
    .a     (opa),
    .b     (opb),
    .t     (t_r[T_FRAC_BITS-1:0]),
    .done  (lerp_done),
    .res   (lerp_res)
  );

  always_comb begin
    state_nxt     = state_r;
    resume_nxt    = resume_r;
    item_nxt      = item_r;
    at_start_nxt  = at_start_r;
    pen_x_nxt     = pen_x_r;
    pen_y_nxt     = pen_y_r;
    start_x_nxt   = start_x_r;
    start_y_nxt   = start_y_r;
    nonempty_nxt  = nonempty_r;
    t_nxt         = t_r;
    k_nxt         = k_r;
    uidx_nxt      = uidx_r;
    axis_nxt      = axis_r;
    s0_nxt        = s0_r;
    s1_nxt        = s1_r;
    s2_nxt        = s2_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    nc_nxt        = nc_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    lerp_start    = 1'b0;

    in_ready    = (state_r == ST_IDLE);
    out_free    = !out_valid_r || out_ready;
    in_at_start = (in_word.end_x == start_x_r) && (in_word.end_y == start_y_r);
    uop         = uop_lookup(item_r.command == CMD_CUBIC, uidx_r);
    opa         = pick(uop.src_a);
    opb         = pick(uop.src_b);
    step_ext    = TW'(param_step);
    t_sum       = t_r + step_ext;
    k_inc       = k_r + K_BITS'(1);
    more        = (t_sum < T_ONE) && (k_inc != MAX_INTERP);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt     = in_word;
          at_start_nxt = in_at_start;
          nc_nxt       = 1'b0;
          resume_nxt   = ST_IDLE;
          unique case (in_word.command)
            CMD_MOVE: begin
              vx_nxt      = in_word.end_x;
              vy_nxt      = in_word.end_y;
              nc_nxt      = nonempty_r;
              last_nxt    = 1'b1;
              start_x_nxt = in_word.end_x;
              start_y_nxt = in_word.end_y;
              pen_x_nxt   = in_word.end_x;
              pen_y_nxt   = in_word.end_y;
              state_nxt   = ST_EMIT;
            end
            CMD_LINE: begin
              if (!in_at_start) begin
                vx_nxt    = in_word.end_x;
                vy_nxt    = in_word.end_y;
                last_nxt  = 1'b1;
                pen_x_nxt = in_word.end_x;
                pen_y_nxt = in_word.end_y;
                state_nxt = ST_EMIT;
              end
            end
            default: begin
              if (curve_mode) begin
                t_nxt     = step_ext;
                k_nxt     = '0;
                uidx_nxt  = '0;
                axis_nxt  = 1'b0;
                state_nxt = (step_ext < T_ONE) ? ST_CALC_ISSUE : ST_CURVE_END;
              end else begin
                vx_nxt     = in_word.ctrl1_x;
                vy_nxt     = in_word.ctrl1_y;
                last_nxt   = (in_word.command == CMD_CONIC) && in_at_start;
                pen_x_nxt  = in_word.ctrl1_x;
                pen_y_nxt  = in_word.ctrl1_y;
                resume_nxt = (in_word.command == CMD_CUBIC) ? ST_PLAIN_C2 : ST_PLAIN_END;
                state_nxt  = ST_EMIT;
              end
            end
          endcase
        end
      end

      ST_PLAIN_C2: begin
        vx_nxt     = item_r.ctrl2_x;
        vy_nxt     = item_r.ctrl2_y;
        last_nxt   = at_start_r;
        pen_x_nxt  = item_r.ctrl2_x;
        pen_y_nxt  = item_r.ctrl2_y;
        resume_nxt = ST_PLAIN_END;
        state_nxt  = ST_EMIT;
      end

      ST_PLAIN_END, ST_CURVE_END: begin
        if (at_start_r) begin
          // plain curves leave the pen on the last control point
          if (state_r == ST_CURVE_END) begin
            pen_x_nxt = item_r.end_x;
            pen_y_nxt = item_r.end_y;
          end
          state_nxt = ST_IDLE;
        end else begin
          vx_nxt     = item_r.end_x;
          vy_nxt     = item_r.end_y;
          last_nxt   = 1'b1;
          pen_x_nxt  = item_r.end_x;
          pen_y_nxt  = item_r.end_y;
          resume_nxt = ST_IDLE;
          state_nxt  = ST_EMIT;
        end
      end

      ST_CALC_ISSUE: begin
        lerp_start = 1'b1;
        state_nxt  = ST_CALC_WAIT;
      end

      ST_CALC_WAIT: begin
        if (lerp_done) begin
          case (uop.dst)
            DST_S0:  s0_nxt = lerp_res;
            DST_S1:  s1_nxt = lerp_res;
            DST_S2:  s2_nxt = lerp_res;
            default: begin
              if (axis_r) vy_nxt = lerp_res;
              else        vx_nxt = lerp_res;
            end
          endcase
          if (!uop.last) begin
            uidx_nxt  = uidx_r + 3'd1;
            state_nxt = ST_CALC_ISSUE;
          end else if (!axis_r) begin
            axis_nxt  = 1'b1;
            uidx_nxt  = '0;
            state_nxt = ST_CALC_ISSUE;
          end else begin
            // y done: ship the vertex and step t
            axis_nxt   = 1'b0;
            uidx_nxt   = '0;
            t_nxt      = t_sum;
            k_nxt      = k_inc;
            last_nxt   = !more && at_start_r;
            resume_nxt = more ? ST_CALC_ISSUE : ST_CURVE_END;
            state_nxt  = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.vert_x      = vx_r;
          out_word_nxt.vert_y      = vy_r;
          out_word_nxt.new_contour = nc_r;
          out_word_nxt.last_vertex = last_r;
          nonempty_nxt             = 1'b1;
          state_nxt                = resume_r;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      nonempty_r  <= 1'b0;
      pen_x_r     <= '0;
      pen_y_r     <= '0;
      start_x_r   <= '0;
      start_y_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      nonempty_r  <= nonempty_nxt;
      pen_x_r     <= pen_x_nxt;
      pen_y_r     <= pen_y_nxt;
      start_x_r   <= start_x_nxt;
      start_y_r   <= start_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    resume_r   <= resume_nxt;
    item_r     <= item_nxt;
    at_start_r <= at_start_nxt;
    t_r        <= t_nxt;
    k_r        <= k_nxt;
    uidx_r     <= uidx_nxt;
    axis_r     <= axis_nxt;
    s0_r       <= s0_nxt;
    s1_r       <= s1_nxt;
    s2_r       <= s2_nxt;
    vx_r       <= vx_nxt;
    vy_r       <= vy_nxt;
    nc_r       <= nc_nxt;
    last_r     <= last_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* rtl/outline_bezier_flattener.sv */
// Outline flattener: takes one path command word (move, line, conic, cubic) at a
// time and returns its outline vertices, the final one flagged last_vertex. A move
// or line goes from acceptance through the emit state into the output register. In
// curve mode every interpolated vertex runs the de Casteljau steps, one at a time,
// through a single shared multiply-and-add interpolator, with up to 63 vertices
// plus the end point per curve. in_ready stays low while a command is in work,
// until its last vertex has been handed to the output register and, for a curve
// that ends on the contour start, its end state has passed. The output register
// holds one word so the next command can start while it waits. Configuration is
// accepted on every cycle.
`include "outline_bezier_flattener_assert.svh"

module outline_bezier_flattener import obf_pkg::*; #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  obf_in_t                 in_word,
  output logic                    out_valid,
  input  logic                    out_ready,
  output obf_out_t                out_word,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [STEP_BITS-1:0]    cfg_data
);

  logic                 curve_mode_r, curve_mode_nxt;
  logic [STEP_BITS-1:0] param_step_r, param_step_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    curve_mode_nxt = curve_mode_r;
    param_step_nxt = param_step_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CURVE_MODE: curve_mode_nxt = cfg_data[0];
        CFG_PARAM_STEP: param_step_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_mode_r <= CURVE_RESET;
      param_step_r <= STEP_RESET;
    end else begin
      curve_mode_r <= curve_mode_nxt;
      param_step_r <= param_step_nxt;
    end
  end

  obf_core #(
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .curve_mode (curve_mode_r),
    .param_step (param_step_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

  // a move always produces a word, so the core must be busy right after it
  `OBF_ASSERT_NEXT(a_move_busy, in_valid && in_ready && (in_word.command == CMD_MOVE), !in_ready, "move accepted but core idle next cycle")
  // only a move word can open a contour, and a move has exactly one word
  `OBF_ASSERT_SAME(a_nc_last, out_valid && out_word.new_contour, out_word.last_vertex, "new contour word not flagged last")
  // words still pending for this command keep the input closed
  `OBF_ASSERT_SAME(a_pending_busy, out_valid && !out_word.last_vertex, !in_ready, "input open with words of a command still pending")

endmodule

/* verif/obf_vertex_checker.sv */
module obf_vertex_checker import obf_pkg::*; #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  obf_in_t                 in_word,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  obf_out_t                out_word,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [STEP_BITS-1:0]    cfg_data,
  output int                      fail_count,
  output int                      vertices_pending
);

  localparam int unsigned T_ONE            = 1 << T_FRAC_BITS;
  localparam int          MAX_CURVE_POINTS = 63;

  logic                 curve_mode;
  logic [STEP_BITS-1:0] param_step;
  coord_t               start_x, start_y, pen_x, pen_y;
  logic                 contour_nonempty;
  obf_out_t             expected_vertices[$];
  int                   fails = 0;
  int                   pending = 0;

  assign fail_count       = fails;
  assign vertices_pending = pending;

  // a + floor((b - a) * t / 2^T_FRAC_BITS)
  function automatic coord_t lerp_q(input coord_t a, input coord_t b, input int unsigned t);
    longint prod;
    prod = (longint'(b) - longint'(a)) * longint'(t);
    return coord_t'(longint'(a) + (prod >>> T_FRAC_BITS));
  endfunction

  task automatic add_vertex(input coord_t x, input coord_t y, input logic nc);
    obf_out_t v;
    v.vert_x      = x;
    v.vert_y      = y;
    v.new_contour = nc;
    v.last_vertex = 1'b0;
    expected_vertices.insert(expected_vertices.size(), v);
    contour_nonempty = 1'b1;
  endtask

  task automatic flatten_command(input obf_in_t w);
    int unsigned t;
    int          k;
    int          first;
    logic        at_start;
    coord_t      ax, ay, bx, by, cx, cy, mx, my, nx, ny;
    first    = expected_vertices.size();
    at_start = (w.end_x == start_x) && (w.end_y == start_y);
    case (w.command)
      CMD_MOVE: begin
        start_x = w.end_x;
        start_y = w.end_y;
        add_vertex(w.end_x, w.end_y, contour_nonempty);
        pen_x = w.end_x;
        pen_y = w.end_y;
      end
      CMD_LINE: begin
        if (!at_start) begin
          add_vertex(w.end_x, w.end_y, 1'b0);
          pen_x = w.end_x;
          pen_y = w.end_y;
        end
      end
      default: begin
        if (curve_mode) begin
          t = param_step;
          k = 0;
          while (t < T_ONE && k < MAX_CURVE_POINTS) begin
            ax = lerp_q(pen_x, w.ctrl1_x, t);
            ay = lerp_q(pen_y, w.ctrl1_y, t);
            if (w.command == CMD_CONIC) begin
              bx = lerp_q(w.ctrl1_x, w.end_x, t);
              by = lerp_q(w.ctrl1_y, w.end_y, t);
              add_vertex(lerp_q(ax, bx, t), lerp_q(ay, by, t), 1'b0);
            end else begin
              bx = lerp_q(w.ctrl1_x, w.ctrl2_x, t);
              by = lerp_q(w.ctrl1_y, w.ctrl2_y, t);
              cx = lerp_q(w.ctrl2_x, w.end_x, t);
              cy = lerp_q(w.ctrl2_y, w.end_y, t);
              mx = lerp_q(ax, bx, t);
              my = lerp_q(ay, by, t);
              nx = lerp_q(bx, cx, t);
              ny = lerp_q(by, cy, t);
              add_vertex(lerp_q(mx, nx, t), lerp_q(my, ny, t), 1'b0);
            end
            k++;
            t += param_step;
          end
          if (!at_start)
            add_vertex(w.end_x, w.end_y, 1'b0);
          pen_x = w.end_x;
          pen_y = w.end_y;
        end else begin
          add_vertex(w.ctrl1_x, w.ctrl1_y, 1'b0);
          pen_x = w.ctrl1_x;
          pen_y = w.ctrl1_y;
          if (w.command == CMD_CUBIC) begin
            add_vertex(w.ctrl2_x, w.ctrl2_y, 1'b0);
            pen_x = w.ctrl2_x;
            pen_y = w.ctrl2_y;
          end
          if (!at_start) begin
            add_vertex(w.end_x, w.end_y, 1'b0);
            pen_x = w.end_x;
            pen_y = w.end_y;
          end
        end
      end
    endcase
    if (expected_vertices.size() > first)
      expected_vertices[expected_vertices.size() - 1].last_vertex = 1'b1;
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      fails++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    obf_out_t want;
    if (!rst_n) begin
      curve_mode       = 1'b1;
      param_step       = 16'd6554;
      start_x          = '0;
      start_y          = '0;
      pen_x            = '0;
      pen_y            = '0;
      contour_nonempty = 1'b0;
      expected_vertices.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_vertices.size() == 0) begin
          fails++;
          $error("vertex word with nothing expected: x %0d y %0d",
                 out_word.vert_x, out_word.vert_y);
        end else begin
          want = expected_vertices.pop_front();
          check_field("vert_x", longint'($signed(want.vert_x)),
                      longint'($signed(out_word.vert_x)));
          check_field("vert_y", longint'($signed(want.vert_y)),
                      longint'($signed(out_word.vert_y)));
          check_field("new_contour", want.new_contour, out_word.new_contour);
          check_field("last_vertex", want.last_vertex, out_word.last_vertex);
        end
      end
      if (in_valid && in_ready)
        flatten_command(in_word);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CURVE_MODE)
          curve_mode = cfg_data[0];
        else if (cfg_index == CFG_PARAM_STEP)
          param_step = cfg_data;
      end
    end
    pending = expected_vertices.size();
  end

endmodule

/* verif/outline_bezier_flattener_tb.sv */
module outline_bezier_flattener_tb;
  import obf_pkg::*;

  localparam int T_FRAC_BITS   = 16;
  localparam int TOTAL_WORDS   = 225;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_WORDS   = 33;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 60;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE0 = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE1 = 2'd3;

  localparam coord_t C_MAX = 24'sh7FFFFF;
  localparam coord_t C_MIN = 24'sh800000;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  obf_in_t                 in_word;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  obf_out_t                out_word;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [STEP_BITS-1:0]    cfg_data;
  int                      fail_count;
  int                      vertices_pending;

  int     send_idle_pct = 24;
  int     recv_idle_pct = 49;
  int     words_sent    = 0;
  coord_t contour_x     = '0;
  coord_t contour_y     = '0;

  outline_bezier_flattener #(.T_FRAC_BITS(T_FRAC_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  obf_vertex_checker #(.T_FRAC_BITS(T_FRAC_BITS)) vertex_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_word          (in_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_word         (out_word),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .vertices_pending (vertices_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #80_000_000;
    $display("outline_bezier_flattener_tb NOT OK");
    $finish;
  end

  function automatic obf_in_t word_of(input cmd_t c, input coord_t c1x, input coord_t c1y,
                                      input coord_t c2x, input coord_t c2y,
                                      input coord_t ex, input coord_t ey);
    obf_in_t w;
    w.command = c;
    w.ctrl1_x = c1x;
    w.ctrl1_y = c1y;
    w.ctrl2_x = c2x;
    w.ctrl2_y = c2y;
    w.end_x   = ex;
    w.end_y   = ey;
    return w;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0:       return C_MAX;
      1:       return C_MIN;
      2, 3, 4: return coord_t'($urandom);
      default: return coord_t'($urandom_range(8191)) - coord_t'(4096);
    endcase
  endfunction

  // random content; a closing command lands on the contour start
  function automatic obf_in_t make_cmd(input cmd_t c, input logic close);
    obf_in_t w;
    w = word_of(c, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord());
    if (close) begin
      w.end_x = contour_x;
      w.end_y = contour_y;
    end
    return w;
  endfunction

  task automatic send_word(input obf_in_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (w.command == CMD_MOVE) begin
      contour_x = w.end_x;
      contour_y = w.end_y;
    end
    // swap the idling profile, then drop idling altogether
    if (words_sent == TOTAL_WORDS / 3) begin
      send_idle_pct <= 49;
      recv_idle_pct <= 24;
    end else if (words_sent == 2 * TOTAL_WORDS / 3) begin
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
    end
  endtask

  // curves that close on the contour start keep the block busy briefly after their last word
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (vertices_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [STEP_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic mode, input logic [STEP_BITS-1:0] step);
    logic [STEP_BITS-1:0] mode_data;
    wait_idle();
    mode_data    = STEP_BITS'($urandom);
    mode_data[0] = mode;
    write_reg(CFG_CURVE_MODE, mode_data);
    write_reg(CFG_PARAM_STEP, step);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_contour();
    int   segs;
    cmd_t c;
    logic close;
    segs = $urandom_range(1, 6);
    send_word(make_cmd(CMD_MOVE, 1'b0));
    for (int i = 0; i < segs; i++) begin
      c     = cmd_t'($urandom_range(1, 3));
      close = ((i == segs - 1) && ($urandom_range(99) < 40)) || ($urandom_range(99) < 5);
      send_word(make_cmd(c, close));
    end
  endtask

  initial begin
    int phase_end;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: line onto the start before any move, then a curve from the origin
    send_word(word_of(CMD_LINE, 24'sd5, -24'sd5, 24'sd7, -24'sd7, '0, '0));
    send_word(word_of(CMD_CONIC, 24'sd1000, -24'sd2000, '0, '0, 24'sd5000, 24'sd3000));
    send_word(word_of(CMD_MOVE, C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX));
    send_word(word_of(CMD_CUBIC, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN));
    send_word(word_of(CMD_CONIC, '0, '0, '0, '0, C_MAX, C_MAX));
    send_word(word_of(CMD_LINE, '0, '0, '0, '0, C_MAX, C_MAX));
    send_word(word_of(CMD_MOVE, '0, '0, '0, '0, -24'sd1, -24'sd1));
    send_word(word_of(CMD_MOVE, '0, '0, '0, '0, 24'sd64, -24'sd64));

    // plain mode, one cubic closing on the start
    configure(1'b0, 16'd6554);
    send_word(word_of(CMD_CONIC, 24'sd100, 24'sd200, '0, '0, 24'sd300, 24'sd400));
    send_word(word_of(CMD_CUBIC, C_MAX, C_MIN, C_MIN, C_MAX, 24'sd64, -24'sd64));
    send_word(make_cmd(CMD_CUBIC, 1'b0));
    send_word(make_cmd(CMD_LINE, 1'b0));

    configure(1'b1, 16'hFFFF);
    send_word(make_cmd(CMD_CONIC, 1'b0));
    send_word(make_cmd(CMD_CUBIC, 1'b0));

    configure(1'b1, 16'd1040);
    send_word(make_cmd(CMD_CUBIC, 1'b0));

    // zero step runs out the interpolation count on the pen point
    configure(1'b1, 16'd0);
    send_word(make_cmd(CMD_CONIC, 1'b0));
    wait_idle();
    write_reg(CFG_IDX_SPARE0, STEP_BITS'($urandom));
    write_reg(CFG_IDX_SPARE1, STEP_BITS'($urandom));
    cfg_valid <= 1'b0;
    send_word(make_cmd(CMD_CUBIC, 1'b0));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       configure(1'b1, STEP_BITS'($urandom_range(4096, 65535)));
        1:       configure(1'b0, STEP_BITS'($urandom));
        2:       configure(1'b1, 16'hFFFF);
        3:       configure(1'b1, STEP_BITS'($urandom_range(1040, 4095)));
        4:       configure(1'b0, STEP_BITS'($urandom));
        default: configure(1'b1, STEP_BITS'($urandom_range(4096, 65535)));
      endcase
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        if ($urandom_range(99) < 15)
          send_word(make_cmd(cmd_t'($urandom_range(3)), 1'($urandom_range(1))));
        else
          random_contour();
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (vertices_pending != 0);
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("outline_bezier_flattener_tb OK");
    else
      $display("outline_bezier_flattener_tb NOT OK");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/obf_pkg.sv
rtl/obf_lerp.sv
rtl/obf_core.sv
rtl/outline_bezier_flattener.sv
verif/obf_vertex_checker.sv
verif/outline_bezier_flattener_tb.sv
